@@ src/cal_pkg.sv @@
// cal_pkg: shared types and codes for the cursor array list
// command and error codes, cell control word and result beat layout
// no dependencies

package cal_pkg;

	// command codes carried on the cmd field
	typedef enum logic [3:0] {
		CMD_APPEND = 4'd0,
		CMD_INSERT = 4'd1,
		CMD_REMOVE = 4'd2,
		CMD_SET    = 4'd3,
		CMD_GET    = 4'd4,
		CMD_GOTO   = 4'd5,
		CMD_NEXT   = 4'd6,
		CMD_PREV   = 4'd7,
		CMD_START  = 4'd8,
		CMD_END    = 4'd9,
		CMD_CLEAR  = 4'd10
	} cmd_t;

	// error codes returned with every result
	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2,
		ERR_RANGE = 2'd3
	} err_t;

	// what the row of cells does on this cycle
	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_INSERT = 2'd2,
		OP_REMOVE = 2'd3
	} cell_op_t;

	// control word broadcast to every cell
	typedef struct packed {
		cell_op_t    op;
		logic [7:0]  elem;
	} cell_cmd_t;

	// one result beat
	typedef struct packed {
		logic [7:0]  value;
		logic [6:0]  cursor;
		logic [6:0]  count;
		err_t        err;
	} res_t;

	// capacity after reset
	localparam logic [6:0] CAPACITY_RST = 7'd64;

endpackage

@@ src/cal_cell.sv @@
// cal_cell: one entry of the list, a byte register
// loads the element, its lower neighbour or its upper neighbour as the control word asks
// depends on cal_pkg

module cal_cell #(
	parameter int CW  = 7,
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  cal_pkg::cell_cmd_t    ctl,
	input  logic [CW-1:0]         pos,
	input  logic [CW-1:0]         last,
	input  logic [7:0]            below,
	input  logic [7:0]            above,
	output logic [7:0]            data
);

	localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
	localparam logic [CW-1:0] NXT_IDX = CW'(IDX + 1);

	logic [7:0] data_q;
	logic [7:0] data_d;
	logic       load;

	// pick the source for this entry
	always_comb begin
		data_d = data_q;
		load   = 1'b0;
		case (ctl.op)
			cal_pkg::OP_WRITE: begin
				if (MY_IDX == pos) begin
					data_d = ctl.elem;
					load   = 1'b1;
				end
			end
			cal_pkg::OP_INSERT: begin
				if (MY_IDX == pos) begin
					data_d = ctl.elem;
					load   = 1'b1;
				end else if (MY_IDX > pos && MY_IDX <= last) begin
					data_d = below;
					load   = 1'b1;
				end
			end
			cal_pkg::OP_REMOVE: begin
				if (MY_IDX >= pos && NXT_IDX < last) begin
					data_d = above;
					load   = 1'b1;
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// entry register, contents undefined until written
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data_d;
		end
	end

	assign data = data_q;

endmodule

@@ src/cal_ctrl.sv @@
// cal_ctrl: command decode, cursor and count registers
// drives the cell control word and forms the result beat
// depends on cal_pkg

module cal_ctrl #(
	parameter int DEPTH = 64,
	parameter int CW    = 7,
	parameter int AW    = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [3:0]            cmd,
	input  logic [7:0]            element,
	input  logic [6:0]            position,
	input  logic [6:0]            capacity,
	input  logic [7:0]            rd_data,
	output logic [AW-1:0]         rd_idx,
	output cal_pkg::cell_cmd_t    cell_cmd,
	output logic [CW-1:0]         pos,
	output logic [CW-1:0]         last,
	output cal_pkg::res_t         res
);

	localparam int XW = (CW > 7) ? CW : 7;
	localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

	logic [CW-1:0] count_q;
	logic [CW-1:0] cursor_q;
	logic [CW-1:0] count_d;
	logic [CW-1:0] cursor_d;

	logic [XW-1:0] cap_x;
	logic [XW-1:0] limit;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] tgt_x;
	logic [XW-1:0] cur_x;
	logic [XW-1:0] cnt_out_x;
	logic [CW:0]   cur_inc;
	logic          full;
	logic          empty;
	logic          at_end;
	cal_pkg::cell_op_t op;
	logic [7:0]    value;
	cal_pkg::err_t err;

	// limit in force is the smaller of capacity and depth
	always_comb begin
		cap_x  = XW'(capacity);
		limit  = (cap_x < DEPTH_X) ? cap_x : DEPTH_X;
		cnt_x  = XW'(count_q);
		tgt_x  = XW'(position);
		full   = (cnt_x >= limit);
		empty  = (count_q == '0);
		at_end = (cursor_q >= count_q);
		cur_inc = {1'b0, cursor_q} + (CW+1)'(1);
	end

	// read address: goto target or the cursor
	assign rd_idx = (cal_pkg::cmd_t'(cmd) == cal_pkg::CMD_GOTO) ? AW'(tgt_x) : AW'(cursor_q);

	// command decode
	always_comb begin
		count_d  = count_q;
		cursor_d = cursor_q;
		op       = cal_pkg::OP_NONE;
		pos      = cursor_q;
		value    = 8'h00;
		err      = cal_pkg::ERR_OK;
		case (cal_pkg::cmd_t'(cmd))
			cal_pkg::CMD_APPEND: begin
				if (full) begin
					err = cal_pkg::ERR_FULL;
				end else begin
					op      = cal_pkg::OP_WRITE;
					pos     = count_q;
					count_d = count_q + CW'(1);
				end
			end
			cal_pkg::CMD_INSERT: begin
				if (full) begin
					err = cal_pkg::ERR_FULL;
				end else begin
					op      = cal_pkg::OP_INSERT;
					count_d = count_q + CW'(1);
				end
			end
			cal_pkg::CMD_REMOVE: begin
				if (empty) begin
					err = cal_pkg::ERR_EMPTY;
				end else if (at_end) begin
					err = cal_pkg::ERR_RANGE;
				end else begin
					op      = cal_pkg::OP_REMOVE;
					value   = rd_data;
					count_d = count_q - CW'(1);
				end
			end
			cal_pkg::CMD_SET: begin
				op = cal_pkg::OP_WRITE;
			end
			cal_pkg::CMD_GET: begin
				if (empty) begin
					err = cal_pkg::ERR_EMPTY;
				end else if (at_end) begin
					err = cal_pkg::ERR_RANGE;
				end else begin
					value = rd_data;
				end
			end
			cal_pkg::CMD_GOTO: begin
				if (tgt_x > cnt_x) begin
					err = cal_pkg::ERR_RANGE;
				end else begin
					cursor_d = CW'(tgt_x);
					if (tgt_x < cnt_x) begin
						value = rd_data;
					end
				end
			end
			cal_pkg::CMD_NEXT: begin
				if (cur_inc < {1'b0, count_q}) begin
					cursor_d = cur_inc[CW-1:0];
				end
			end
			cal_pkg::CMD_PREV: begin
				if (cursor_q != '0) begin
					cursor_d = cursor_q - CW'(1);
				end
			end
			cal_pkg::CMD_START: begin
				cursor_d = '0;
			end
			cal_pkg::CMD_END: begin
				cursor_d = empty ? '0 : count_q - CW'(1);
			end
			cal_pkg::CMD_CLEAR: begin
				count_d  = '0;
				cursor_d = '0;
			end
			default: begin
				err = cal_pkg::ERR_OK;
			end
		endcase
	end

	// cells move only on an accepted beat
	assign cell_cmd.op   = accept ? op : cal_pkg::OP_NONE;
	assign cell_cmd.elem = element;
	assign last          = count_q;

	// result beat, positions cut to the field width
	always_comb begin
		cur_x      = XW'(cursor_d);
		cnt_out_x  = XW'(count_d);
		res.value  = value;
		res.cursor = cur_x[6:0];
		res.count  = cnt_out_x[6:0];
		res.err    = err;
	end

	// cursor and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
		end else if (accept) begin
			count_q  <= count_d;
			cursor_q <= cursor_d;
		end
	end

endmodule

@@ src/cursor_array_list_unit.sv @@
// cursor_array_list_unit: byte list with a cursor built as a row of entry cells
// an accepted command's result is registered in the result register or the skid stage
// one command per cycle while cmd_stall is low; insert and remove shift cells at once
// the result register and a one-beat skid stage let a command in while a result waits
// reset: count and cursor go to zero, capacity to 64; entry contents stay undefined
// depends on cal_pkg, cal_ctrl, cal_cell

module cursor_array_list_unit #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  capacity,
	// command channel
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [3:0]  cmd,
	input  logic [7:0]  element,
	input  logic [6:0]  position,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  value,
	output logic [6:0]  cursor,
	output logic [6:0]  count,
	output logic [1:0]  error_code
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	logic [6:0]          capacity_q;
	logic                cmd_accept;
	logic                res_take;
	logic [AW-1:0]       rd_idx;
	logic [7:0]          rd_data;
	logic [CW-1:0]       pos;
	logic [CW-1:0]       last;
	cal_pkg::cell_cmd_t  cell_cmd;
	cal_pkg::res_t       ctrl_res;
	cal_pkg::res_t       res_q;
	cal_pkg::res_t       skid_q;
	logic                res_valid_q;
	logic                skid_valid_q;
	logic [7:0]          cell_data [DEPTH];
	logic [7:0]          below_data [DEPTH];
	logic [7:0]          above_data [DEPTH];

	// handshakes
	assign cfg_ready  = 1'b1;
	assign cmd_stall  = skid_valid_q;
	assign cmd_accept = cmd_valid && !skid_valid_q;
	assign res_take   = res_valid_q && !res_stall;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= cal_pkg::CAPACITY_RST;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= capacity;
		end
	end

	// command decode and list state
	cal_ctrl #(
		.DEPTH (DEPTH),
		.CW    (CW),
		.AW    (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (cmd_accept),
		.cmd      (cmd),
		.element  (element),
		.position (position),
		.capacity (capacity_q),
		.rd_data  (rd_data),
		.rd_idx   (rd_idx),
		.cell_cmd (cell_cmd),
		.pos      (pos),
		.last     (last),
		.res      (ctrl_res)
	);

	// row of entry cells with neighbour links
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign below_data[g] = 8'h00;
		end else begin : g_mid_lo
			assign below_data[g] = cell_data[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign above_data[g] = 8'h00;
		end else begin : g_mid_hi
			assign above_data[g] = cell_data[g+1];
		end

		cal_cell #(
			.CW  (CW),
			.IDX (g)
		) u_cell (
			.clk   (clk),
			.ctl   (cell_cmd),
			.pos   (pos),
			.last  (last),
			.below (below_data[g]),
			.above (above_data[g]),
			.data  (cell_data[g])
		);
	end

	// read port at the cursor or goto target
	assign rd_data = cell_data[rd_idx];

	// result register and skid stage, valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (res_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (cmd_accept) begin
			if (res_valid_q && !res_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				res_valid_q <= 1'b1;
			end
		end else if (res_take) begin
			res_valid_q <= 1'b0;
		end
	end

	// result and skid payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (res_take) begin
				res_q <= skid_q;
			end
		end else if (cmd_accept) begin
			if (res_valid_q && !res_take) begin
				skid_q <= ctrl_res;
			end else begin
				res_q <= ctrl_res;
			end
		end
	end

	assign res_valid  = res_valid_q;
	assign value      = res_q.value;
	assign cursor     = res_q.cursor;
	assign count      = res_q.count;
	assign error_code = res_q.err;

`ifndef NO_ASSERTIONS
	// a beat in the skid stage means the result register is full too
	a_skid_implies_res: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("skid stage holds a beat while the result register is empty");

	// an accepted command always leaves a result ready next cycle
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_accept |=> res_valid_q)
		else $error("accepted command produced no result beat");

	// a rejected command must leave every cell alone
	a_error_holds_cells: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_accept && ctrl_res.err != cal_pkg::ERR_OK) |-> (cell_cmd.op == cal_pkg::OP_NONE))
		else $error("cells moved on a command that reported an error");

	// count never exceeds the number of cells
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		last <= CW'(DEPTH))
		else $error("entry count exceeds depth");
`endif

endmodule
